[src/obm_pkg.sv]
// Shared types, codes and constants for the order book matcher.
package obm_pkg;

   localparam int NUM_SYMBOLS_DEF = 16;
   localparam int BOOK_DEPTH_DEF  = 16;
   localparam int CSR_ADDR_W      = 3;

   localparam logic REQ_CANCEL  = 1'b1;
   localparam logic SIDE_BUY    = 1'b0;
   localparam logic KIND_MARKET = 1'b1;
   localparam logic REG_TOL     = 1'b0;
   localparam logic REG_MKT     = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [3:0]  symbol;
      logic        side;
      logic        order_kind;
      logic [15:0] client;
      logic [31:0] price;
      logic [31:0] quantity;
      logic [31:0] cancel_id;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  report_kind;
      logic [31:0] order_id;
      logic [15:0] client_out;
      logic [3:0]  symbol_out;
      logic [31:0] fill_qty;
      logic [31:0] fill_price;
      logic [31:0] leave_qty;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] order_num;
      logic [15:0] client;
      logic [31:0] price;
      logic [31:0] qty;
   } entry_type;

   typedef enum logic [2:0] {
      RPT_ACCEPT    = 3'd0,
      RPT_FILL      = 3'd1,
      RPT_CANCELED  = 3'd2,
      RPT_NOT_FOUND = 3'd3,
      RPT_BOOK_FULL = 3'd4
   } report_kind_type;

   typedef enum logic [2:0] {
      SEL_ACCEPT,
      SEL_BAD_SYM,
      SEL_FILL_IN,
      SEL_FILL_RS,
      SEL_CANCELED,
      SEL_NOT_FOUND,
      SEL_FULL
   } push_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_EVAL,
      ST_FILL_IN,
      ST_FILL_RS,
      ST_REST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         cap;
      logic         init_new;
      logic         init_cnx;
      logic         end_pass;
      logic         next_book;
      logic         keep;
      logic         hit;
      logic         trade;
      logic         fill_in;
      logic         fill_rs;
      logic         rest;
      logic         flush;
      logic         push;
      push_sel_type push_sel;
   } cmd_type;

   typedef struct packed {
      logic is_cancel;
      logic sym_bad;
      logic pass_end;
      logic take;
      logic found;
      logic last_book;
      logic rem_nz;
      logic own_full;
   } sts_type;

endpackage

[src/order_book_matcher_unit.sv]
// Top level of the order book matcher: sequencer plus datapath.
// A new order walks every resting entry of the opposite book, with fill states for each match;
//   a cancel walks the books in turn until one holds the order or it has scanned every book.
// Throughput: one request at a time; the next is taken in the idle cycle after busy drops.
// Reset: synchronous; book fill counts clear at once, so all books read empty.
module order_book_matcher_unit #(
   parameter int NUM_SYMBOLS = obm_pkg::NUM_SYMBOLS_DEF,
   parameter int BOOK_DEPTH  = obm_pkg::BOOK_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           start,
   output logic                           busy,
   input  obm_pkg::req_item_type          req_data,
   // report channel: one cycle strobe, no back pressure
   output logic                           rsp_strobe,
   output obm_pkg::rsp_item_type          rsp_data,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [obm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);
   import obm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // zero wait state register port
   assign csr_pready = 1'b1;

   // sequencer: decides walk steps and which report is pushed
   obm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // datapath: book store, counts, pointers and report stage
   obm_dp #(
      .NUM_SYMBOLS (NUM_SYMBOLS),
      .BOOK_DEPTH  (BOOK_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

[src/obm_ctrl.sv]
// Sequencer for the order book matcher: walks books and orders reports.
module obm_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  obm_pkg::sts_type sts,
   output obm_pkg::cmd_type cmd,
   output logic            busy
);
   import obm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.is_cancel) state_in = ST_READ;
            else if (sts.sym_bad) state_in = ST_DONE;
            else state_in = ST_READ;
         end
         ST_READ: begin
            if (!sts.pass_end) state_in = ST_EVAL;
            else if (!sts.is_cancel) state_in = ST_REST;
            else if (sts.found || sts.last_book) state_in = ST_DONE;
            else state_in = ST_READ;
         end
         ST_EVAL: begin
            if (sts.take && !sts.is_cancel) state_in = ST_FILL_IN;
            else state_in = ST_READ;
         end
         ST_FILL_IN: state_in = ST_FILL_RS;
         ST_FILL_RS: state_in = ST_READ;
         ST_REST:    state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.push_sel = SEL_ACCEPT;
      case (state_ff)
         ST_IDLE: begin
            cmd.cap = start;
         end
         ST_CHECK: begin
            if (sts.is_cancel) begin
               cmd.init_cnx = 1'b1;
            end else if (sts.sym_bad) begin
               cmd.push     = 1'b1;
               cmd.push_sel = SEL_BAD_SYM;
            end else begin
               cmd.init_new = 1'b1;
               cmd.push     = 1'b1;
               cmd.push_sel = SEL_ACCEPT;
            end
         end
         ST_READ: begin
            if (sts.pass_end) begin
               cmd.end_pass = 1'b1;
               if (sts.is_cancel && !sts.found) begin
                  if (sts.last_book) begin
                     cmd.push     = 1'b1;
                     cmd.push_sel = SEL_NOT_FOUND;
                  end else begin
                     cmd.next_book = 1'b1;
                  end
               end
            end
         end
         ST_EVAL: begin
            if (!sts.take) begin
               cmd.keep = 1'b1;
            end else if (sts.is_cancel) begin
               cmd.hit      = 1'b1;
               cmd.push     = 1'b1;
               cmd.push_sel = SEL_CANCELED;
            end else begin
               cmd.trade = 1'b1;
            end
         end
         ST_FILL_IN: begin
            cmd.fill_in  = 1'b1;
            cmd.push     = 1'b1;
            cmd.push_sel = SEL_FILL_IN;
         end
         ST_FILL_RS: begin
            cmd.fill_rs  = 1'b1;
            cmd.push     = 1'b1;
            cmd.push_sel = SEL_FILL_RS;
         end
         ST_REST: begin
            cmd.rest = 1'b1;
            if (sts.rem_nz && sts.own_full) begin
               cmd.push     = 1'b1;
               cmd.push_sel = SEL_FULL;
            end
         end
         ST_DONE: begin
            cmd.flush = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[src/obm_dp.sv]
// Datapath: book memory, book fill counts, walk pointers, report holding stage.
module obm_dp #(
   parameter int NUM_SYMBOLS = obm_pkg::NUM_SYMBOLS_DEF,
   parameter int BOOK_DEPTH  = obm_pkg::BOOK_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  obm_pkg::req_item_type           req_data,
   input  obm_pkg::cmd_type                cmd,
   output obm_pkg::sts_type                sts,
   output logic                            rsp_strobe,
   output obm_pkg::rsp_item_type           rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [obm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata
);
   import obm_pkg::*;

   localparam int SW     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int DW     = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int CW     = $clog2(BOOK_DEPTH + 1);
   localparam int BK_W   = SW + 1;
   localparam int NB     = 2 * NUM_SYMBOLS;
   localparam int AW     = BK_W + DW;
   localparam int MEM_D  = 2 ** AW;

   entry_type mem [MEM_D];
   entry_type rd_ff;

   req_item_type req_ff, req_in;
   logic [31:0]   nxt_ff, nxt_in, id_ff, id_in, rem_ff, rem_in, t_ff, t_in;
   logic          ran_ff, ran_in, found_ff, found_in;
   logic [BK_W-1:0] bk_ff, bk_in;
   logic [CW-1:0] r_ff, r_in, w_ff, w_in;
   logic [CW-1:0] cnt_ff [NB];
   logic [CW-1:0] cnt_in [NB];
   rsp_item_type  pend_ff, pend_in, rpt;
   logic          pend_v_ff, pend_v_in;
   logic [15:0]   tol_ff, tol_in;
   logic [31:0]   mkt_ff, mkt_in;

   logic [BK_W-1:0] own_bk, opp_bk;
   logic [CW-1:0]   own_cnt, cur_cnt;
   logic            own_full, rem_nz, skip, take_new, hit;
   logic [32:0]     lo_side, hi_side;
   logic [31:0]     t_calc, rs_left, id_calc, rest_price;
   logic            we;
   logic [AW-1:0]   wa, ra;
   entry_type       wd;
   logic            csr_wr;

   // book indexes and book state
   assign own_bk   = {SW'(req_ff.symbol), req_ff.side};
   assign opp_bk   = {SW'(req_ff.symbol), ~req_ff.side};
   assign own_cnt  = cnt_ff[own_bk];
   assign cur_cnt  = cnt_ff[bk_ff];
   assign own_full = (own_cnt == CW'(BOOK_DEPTH));
   assign rem_nz   = (rem_ff != 32'd0);
   assign id_calc  = nxt_ff + 32'd1;

   // price window: buy skips resting above price+tol, sell skips below price-tol
   always_comb begin
      if (req_ff.side == SIDE_BUY) begin
         lo_side = {1'b0, req_ff.price} + {17'd0, tol_ff};
         hi_side = {1'b0, rd_ff.price};
      end else begin
         lo_side = {1'b0, rd_ff.price} + {17'd0, tol_ff};
         hi_side = {1'b0, req_ff.price};
      end
      skip = (lo_side < hi_side);
   end

   assign take_new = rem_nz && (rd_ff.client != req_ff.client) && !skip;
   assign hit      = !found_ff && (rd_ff.order_num == req_ff.cancel_id);
   assign t_calc   = (rd_ff.qty < rem_ff) ? rd_ff.qty : rem_ff;
   assign rs_left  = rd_ff.qty - t_ff;
   assign rest_price = (req_ff.order_kind == KIND_MARKET && ran_ff) ? mkt_ff : req_ff.price;

   always_comb begin
      sts.is_cancel = (req_ff.req_type == REQ_CANCEL);
      sts.sym_bad   = (32'(req_ff.symbol) >= NUM_SYMBOLS);
      sts.pass_end  = (r_ff == cur_cnt);
      sts.take      = sts.is_cancel ? hit : take_new;
      sts.found     = found_ff;
      sts.last_book = (bk_ff == BK_W'(NB - 1));
      sts.rem_nz    = rem_nz;
      sts.own_full  = own_full;
   end

   // book memory: one write port, one registered read port
   assign ra = {bk_ff, r_ff[DW-1:0]};

   always_comb begin
      we = 1'b0;
      wa = {bk_ff, w_ff[DW-1:0]};
      wd = rd_ff;
      if (cmd.keep) begin
         we = 1'b1;
      end else if (cmd.fill_rs) begin
         we     = (rs_left != 32'd0);
         wd.qty = rs_left;
      end else if (cmd.rest) begin
         we = rem_nz && !own_full;
         wa = {own_bk, own_cnt[DW-1:0]};
         wd = '{order_num: id_ff, client: req_ff.client, price: rest_price, qty: rem_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[ra];
   end

   // report selection
   always_comb begin
      rpt = '0;
      rpt.client_out = req_ff.client;
      rpt.symbol_out = req_ff.symbol;
      case (cmd.push_sel)
         SEL_ACCEPT: begin
            rpt.report_kind = RPT_ACCEPT;
            rpt.order_id    = id_calc;
            rpt.leave_qty   = req_ff.quantity;
         end
         SEL_BAD_SYM: begin
            rpt.report_kind = RPT_BOOK_FULL;
            rpt.leave_qty   = req_ff.quantity;
         end
         SEL_FILL_IN: begin
            rpt.report_kind = RPT_FILL;
            rpt.order_id    = id_ff;
            rpt.fill_qty    = t_ff;
            rpt.fill_price  = rd_ff.price;
            rpt.leave_qty   = rem_ff - t_ff;
         end
         SEL_FILL_RS: begin
            rpt.report_kind = RPT_FILL;
            rpt.order_id    = rd_ff.order_num;
            rpt.client_out  = rd_ff.client;
            rpt.fill_qty    = t_ff;
            rpt.fill_price  = rd_ff.price;
            rpt.leave_qty   = rs_left;
         end
         SEL_CANCELED: begin
            rpt.report_kind = RPT_CANCELED;
            rpt.order_id    = req_ff.cancel_id;
            rpt.client_out  = rd_ff.client;
            rpt.symbol_out  = 4'(bk_ff[BK_W-1:1]);
            rpt.fill_qty    = rd_ff.qty;
            rpt.fill_price  = rd_ff.price;
            rpt.leave_qty   = rd_ff.qty;
         end
         SEL_NOT_FOUND: begin
            rpt.report_kind = RPT_NOT_FOUND;
            rpt.order_id    = req_ff.cancel_id;
            rpt.client_out  = 16'd0;
            rpt.symbol_out  = 4'd0;
         end
         SEL_FULL: begin
            rpt.report_kind = RPT_BOOK_FULL;
            rpt.order_id    = id_ff;
            rpt.leave_qty   = rem_ff;
         end
         default: rpt = '0;
      endcase
   end

   // one report held back so the final one can carry last
   always_comb begin
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      if (cmd.push) begin
         pend_in   = rpt;
         pend_v_in = 1'b1;
      end else if (cmd.flush) begin
         pend_v_in = 1'b0;
      end
   end

   assign rsp_strobe = pend_v_ff && (cmd.push || cmd.flush);
   always_comb begin
      rsp_data      = pend_ff;
      rsp_data.last = cmd.flush;
   end

   // walk state
   always_comb begin
      req_in   = cmd.cap ? req_data : req_ff;
      nxt_in   = cmd.init_new ? id_calc : nxt_ff;
      id_in    = cmd.init_new ? id_calc : id_ff;
      ran_in   = cmd.init_new ? (cnt_ff[opp_bk] != '0) : ran_ff;
      t_in     = cmd.trade ? t_calc : t_ff;
      rem_in   = rem_ff;
      if (cmd.init_new) rem_in = req_ff.quantity;
      else if (cmd.fill_in) rem_in = rem_ff - t_ff;
      found_in = found_ff;
      if (cmd.init_cnx) found_in = 1'b0;
      else if (cmd.hit) found_in = 1'b1;
      bk_in = bk_ff;
      if (cmd.init_new) bk_in = opp_bk;
      else if (cmd.init_cnx) bk_in = '0;
      else if (cmd.next_book) bk_in = bk_ff + 1'b1;
      r_in = r_ff;
      w_in = w_ff;
      if (cmd.init_new || cmd.init_cnx || cmd.next_book) begin
         r_in = '0;
         w_in = '0;
      end else begin
         if (cmd.keep || cmd.hit || cmd.fill_rs) r_in = r_ff + 1'b1;
         if (cmd.keep || (cmd.fill_rs && rs_left != 32'd0)) w_in = w_ff + 1'b1;
      end
      cnt_in = cnt_ff;
      if (cmd.end_pass) cnt_in[bk_ff] = w_ff;
      else if (cmd.rest && rem_nz && !own_full) cnt_in[own_bk] = own_cnt + 1'b1;
   end

   // registers
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      tol_in = tol_ff;
      mkt_in = mkt_ff;
      if (csr_wr && csr_paddr[2] == REG_TOL) tol_in = csr_pwdata[15:0];
      if (csr_wr && csr_paddr[2] == REG_MKT) mkt_in = csr_pwdata;
   end
   assign csr_prdata = (csr_paddr[2] == REG_MKT) ? mkt_ff : {16'd0, tol_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         nxt_ff    <= '0;
         pend_v_ff <= 1'b0;
         tol_ff    <= '0;
         mkt_ff    <= '0;
         for (int i = 0; i < NB; i++) cnt_ff[i] <= '0;
      end else begin
         nxt_ff    <= nxt_in;
         pend_v_ff <= pend_v_in;
         tol_ff    <= tol_in;
         mkt_ff    <= mkt_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      id_ff    <= id_in;
      ran_ff   <= ran_in;
      t_ff     <= t_in;
      rem_ff   <= rem_in;
      found_ff <= found_in;
      bk_ff    <= bk_in;
      r_ff     <= r_in;
      w_ff     <= w_in;
      pend_ff  <= pend_in;
   end

endmodule

[src/obm_checker.sv]
// Port-level checks for the order book matcher and their bind.
module obm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_strobe,
   input obm_pkg::rsp_item_type          rsp_data
);
   import obm_pkg::*;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request taken but not busy");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !rsp_strobe) else $error("report while idle");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !busy && !rsp_strobe)
      else $error("block still busy after final report");

   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.report_kind <= RPT_BOOK_FULL)
      else $error("bad report kind");

endmodule

bind order_book_matcher_unit obm_checker u_obm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[tb/order_book_checker.sv]
// Checker for the order book matcher: mirrors the books, predicts reports, compares.
module order_book_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  obm_pkg::req_item_type          req_data,
   input  logic                           rsp_strobe,
   input  obm_pkg::rsp_item_type          rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [obm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   input  logic                           csr_pready,
   output int                             errors,
   output int                             outstanding,
   output int                             fills_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import obm_pkg::*;

   localparam int NSYM  = NUM_SYMBOLS_DEF;
   localparam int DEPTH = BOOK_DEPTH_DEF;

   logic        book_valid [NSYM][2][DEPTH];
   entry_type   book_entry [NSYM][2][DEPTH];
   logic [31:0] last_order_num;
   logic [15:0] tolerance;
   logic [31:0] market_px;

   rsp_item_type expected_reports[$];

   initial begin
      errors     = 0;
      fills_seen = 0;
   end

   task automatic clear_books();
      foreach (book_valid[s, b, i]) book_valid[s][b][i] = 1'b0;
      last_order_num = '0;
      tolerance      = '0;
      market_px      = '0;
      expected_reports.delete();
   endtask

   task automatic drop_entry(input int s, input int b, input int i);
      for (int j = i; j + 1 < DEPTH; j++) begin
         book_valid[s][b][j] = book_valid[s][b][j+1];
         book_entry[s][b][j] = book_entry[s][b][j+1];
      end
      book_valid[s][b][DEPTH-1] = 1'b0;
   endtask

   function automatic rsp_item_type mk(input report_kind_type k, input logic [31:0] id,
                                       input logic [15:0] cl, input logic [3:0] sym,
                                       input logic [31:0] fq, input logic [31:0] fp,
                                       input logic [31:0] lq);
      rsp_item_type r;
      r.report_kind = k;
      r.order_id    = id;
      r.client_out  = cl;
      r.symbol_out  = sym;
      r.fill_qty    = fq;
      r.fill_price  = fp;
      r.leave_qty   = lq;
      r.last        = 1'b0;
      return r;
   endfunction

   // work out every report one request causes and update the mirrored books
   task automatic predict_reports(input req_item_type rq);
      rsp_item_type batch[$];
      entry_type    e;
      logic [31:0]  id, filled, rem, t, rest_px;
      logic [33:0]  in_px, rs_px;
      int           s, sd, opp, i;
      bit           found, ran, skip;

      if (rq.req_type == REQ_CANCEL) begin
         found = 0;
         for (int ss = 0; ss < NSYM && !found; ss++)
            for (int b = 0; b < 2 && !found; b++)
               for (int k = 0; k < DEPTH && !found; k++)
                  if (book_valid[ss][b][k] && book_entry[ss][b][k].order_num == rq.cancel_id) begin
                     e = book_entry[ss][b][k];
                     batch = {batch, mk(RPT_CANCELED, rq.cancel_id, e.client, 4'(ss),
                                        e.qty, e.price, e.qty)};
                     drop_entry(ss, b, k);
                     found = 1;
                  end
         if (!found) batch = {batch, mk(RPT_NOT_FOUND, rq.cancel_id, '0, '0, '0, '0, '0)};
      end else if (32'(rq.symbol) >= NSYM) begin
         // unknown instrument: no order number, single book full report
         batch = {batch, mk(RPT_BOOK_FULL, '0, rq.client, rq.symbol, '0, '0, rq.quantity)};
      end else begin
         s   = rq.symbol;
         sd  = rq.side;
         opp = sd ^ 1;
         last_order_num = last_order_num + 1;
         id      = last_order_num;
         filled  = '0;
         ran     = 0;
         rest_px = rq.price;
         batch = {batch, mk(RPT_ACCEPT, id, rq.client, rq.symbol, '0, '0, rq.quantity)};
         if (book_valid[s][opp][0]) begin
            ran = 1;
            i   = 0;
            while (i < DEPTH && book_valid[s][opp][i] && filled < rq.quantity) begin
               e     = book_entry[s][opp][i];
               in_px = {2'b00, rq.price};
               rs_px = {2'b00, e.price};
               if (e.client == rq.client) begin
                  i++;
                  continue;
               end
               // price slack is applied without wrap-around
               if (sd == SIDE_BUY) skip = (in_px + tolerance) < rs_px;
               else skip = in_px > (rs_px + tolerance);
               if (skip) begin
                  i++;
                  continue;
               end
               t = rq.quantity - filled;
               if (e.qty < t) t = e.qty;
               filled = filled + t;
               batch = {batch, mk(RPT_FILL, id, rq.client, rq.symbol, t, e.price,
                                  rq.quantity - filled)};
               batch = {batch, mk(RPT_FILL, e.order_num, e.client, rq.symbol, t, e.price,
                                  e.qty - t)};
               book_entry[s][opp][i].qty = e.qty - t;
               if (e.qty == t) drop_entry(s, opp, i);
               else i++;
            end
         end
         rem = rq.quantity - filled;
         if (rem != 0) begin
            if (rq.order_kind == KIND_MARKET && ran) rest_px = market_px;
            for (i = 0; i < DEPTH; i++)
               if (!book_valid[s][sd][i]) break;
            if (i >= DEPTH) begin
               batch = {batch, mk(RPT_BOOK_FULL, id, rq.client, rq.symbol, '0, '0, rem)};
            end else begin
               book_valid[s][sd][i] = 1'b1;
               book_entry[s][sd][i] = '{order_num: id, client: rq.client,
                                        price: rest_px, qty: rem};
            end
         end
      end
      batch[batch.size()-1].last = 1'b1;
      expected_reports = {expected_reports, batch};
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic compare_report(input rsp_item_type got);
      rsp_item_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("unexpected report, order_id", got.order_id, 32'd0);
         return;
      end
      want = expected_reports.pop_front();
      if (got.report_kind == RPT_FILL) fills_seen++;
      if (got.report_kind !== want.report_kind)
         report_mismatch("report_kind", got.report_kind, want.report_kind);
      if (got.order_id !== want.order_id) report_mismatch("order_id", got.order_id, want.order_id);
      if (got.client_out !== want.client_out)
         report_mismatch("client_out", got.client_out, want.client_out);
      if (got.symbol_out !== want.symbol_out)
         report_mismatch("symbol_out", got.symbol_out, want.symbol_out);
      if (got.fill_qty !== want.fill_qty) report_mismatch("fill_qty", got.fill_qty, want.fill_qty);
      if (got.fill_price !== want.fill_price)
         report_mismatch("fill_price", got.fill_price, want.fill_price);
      if (got.leave_qty !== want.leave_qty)
         report_mismatch("leave_qty", got.leave_qty, want.leave_qty);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_books();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == CSR_ADDR_W'(4 * REG_TOL)) tolerance = csr_pwdata[15:0];
            else if (csr_paddr == CSR_ADDR_W'(4 * REG_MKT)) market_px = csr_pwdata;
         end
         if (start && !busy) predict_reports(req_data);
         if (rsp_strobe) compare_report(rsp_data);
      end
      outstanding = expected_reports.size();
   end

endmodule

[tb/testbench.sv]
// Testbench top for the order book matcher: stimulus, register writes and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import obm_pkg::*;

   // watchdog limit, with plenty of margin above the worst walk of any request
   localparam int CYCLE_LIMIT = 1000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_item_type          req_data = '0;
   logic                  rsp_strobe;
   rsp_item_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int errors, outstanding, fills_seen;
   int cycles = 0;
   int requests_sent = 0;
   int orders_sent = 0;   // order numbers are handed out in sequence from 1

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   order_book_matcher_unit dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   order_book_checker checker_i (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .errors, .outstanding, .fills_seen
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL order_book_matcher_unit");
         $finish;
      end
   end

   // present a request and hold it until busy is seen low; start stays up on return
   task automatic send(input req_item_type rq);
      start    <= 1'b1;
      req_data <= rq;
      do @(negedge clock); while (busy);
      @(posedge clock);
      requests_sent++;
      if (rq.req_type != REQ_CANCEL) orders_sent++;
   endtask

   task automatic send_new(input logic [3:0] sym, input logic sd, input logic kind,
                           input logic [15:0] cl, input logic [31:0] px,
                           input logic [31:0] qty);
      req_item_type rq;
      rq = '0;
      rq.symbol     = sym;
      rq.side       = sd;
      rq.order_kind = kind;
      rq.client     = cl;
      rq.price      = px;
      rq.quantity   = qty;
      rq.cancel_id  = $urandom;   // ignored on a new order
      send(rq);
   endtask

   task automatic send_cancel(input logic [31:0] id);
      req_item_type rq;
      rq = '{default: '0};
      rq.req_type  = REQ_CANCEL;
      rq.symbol    = 4'($urandom);
      rq.client    = 16'($urandom);
      rq.cancel_id = id;
      send(rq);
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // settle: every report in and the walk finished
   task automatic drain();
      pause(1);
      do @(negedge clock); while (outstanding != 0 || busy);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(input logic [15:0] tol, input logic [31:0] mkt);
      csr_write(CSR_ADDR_W'(4 * REG_TOL), {16'h0, tol});
      csr_write(CSR_ADDR_W'(4 * REG_MKT), mkt);
   endtask

   // random request: mostly a crowded market near one price, some wide noise
   task automatic random_request();
      int          pick;
      logic [31:0] id;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         if (orders_sent > 0 && $urandom_range(0, 3) != 0)
            id = 32'($urandom_range(orders_sent > 30 ? orders_sent - 30 : 1, orders_sent));
         else id = $urandom;
         send_cancel(id);
      end else if (pick < 22) begin
         send_new(4'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), $urandom,
                  ($urandom_range(0, 1) ? $urandom : 32'($urandom_range(1, 100))) | 32'h1);
      end else begin
         send_new(4'($urandom_range(0, 3)), 1'($urandom),
                  1'($urandom_range(0, 6) == 0), 16'($urandom_range(1, 6)),
                  32'(1000 + $urandom_range(0, 40) - 20), 32'($urandom_range(1, 60)));
      end
   endtask

   // bursts of back-to-back requests, with a random gap after most bursts
   task automatic random_phase(input int n);
      int left, burst;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 8);
         if (burst > left) burst = left;
         repeat (burst) random_request();
         left -= burst;
         if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: defaults first
      set_regs(16'h0, 32'h0);
      send_new(4'd0, 1'b0, 1'b0, 16'd1, 32'd100, 32'd10);        // rests, empty book
      send_new(4'd0, 1'b1, 1'b0, 16'd1, 32'd100, 32'd5);         // own client skipped
      send_new(4'd0, 1'b1, 1'b0, 16'd2, 32'd100, 32'd4);         // partial fill
      send_new(4'd0, 1'b1, 1'b0, 16'd2, 32'd101, 32'd3);         // outside tolerance
      send_new(4'd0, 1'b0, KIND_MARKET, 16'd3, 32'd0, 32'd20);   // market, rests at register
      send_new(4'd0, 1'b1, KIND_MARKET, 16'd4, 32'd0, 32'd50);   // sweeps buys
      pause(3);
      send_cancel(32'd2);                                        // found
      send_cancel(32'd2);                                        // gone now
      send_cancel(32'hFFFF_FFFF);
      send_new(4'd15, 1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_new(4'd15, 1'b1, 1'b0, 16'h0, 32'h0, 32'hFFFF_FFFF);  // full cross
      send_new(4'd5, 1'b1, 1'b0, 16'd9, 32'd7, 32'd0);           // zero quantity
      drain();

      // extreme registers: full tolerance widens the crossing window, market orders rest at the top
      set_regs(16'hFFFF, 32'hFFFF_FFFF);
      send_new(4'd1, 1'b1, 1'b0, 16'd1, 32'd70000, 32'd8);
      send_new(4'd1, 1'b0, 1'b0, 16'd2, 32'd4465, 32'd3);        // just within slack
      send_new(4'd1, 1'b0, 1'b0, 16'd2, 32'd4464, 32'd3);        // just outside
      send_new(4'd1, 1'b0, KIND_MARKET, 16'd3, 32'd70000, 32'd9);
      // flood one book past its depth
      repeat (BOOK_DEPTH_DEF + 1)
         send_new(4'd9, 1'b0, 1'b0, 16'd77, 32'($urandom_range(1, 500)), 32'd5);
      drain();
      random_phase(55);
      drain();

      set_regs(16'h0, 32'h0);
      random_phase(55);
      drain();

      set_regs(16'($urandom_range(1, 30)), 32'($urandom_range(980, 1020)));
      random_phase(55);
      drain();

      repeat (50) @(posedge clock);
      $display("Ran %0d requests (%0d new orders), %0d fill reports checked.",
               requests_sent, orders_sent, fills_seen);
      $display("Register settings covered zero and full tolerance and market price.");
      if (errors == 0 && outstanding == 0) begin
         $display("PASS order_book_matcher_unit");
      end else begin
         $display("FAIL order_book_matcher_unit");
      end
      $finish;
   end

endmodule

[sim.f]
src/obm_pkg.sv
src/obm_ctrl.sv
src/obm_dp.sv
src/order_book_matcher_unit.sv
src/obm_checker.sv
tb/order_book_checker.sv
tb/testbench.sv
